[hdl/indexed_list_engine_macros.svh]
// Assertion macros used by the port-level checker of the indexed list engine.
`ifndef INDEXED_LIST_ENGINE_MACROS_SVH
`define INDEXED_LIST_ENGINE_MACROS_SVH

// Concurrent assertion that is switched off while reset is asserted.
`define ILE_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("indexed list engine assertion failed");

// Concurrent assertion that is checked during reset as well.
`define ILE_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("indexed list engine assertion failed");

`endif

[hdl/ile_pkg.sv]
// Package with the types, codes and constants of the indexed list engine.
`timescale 1ns / 1ps

package ile_pkg;

    localparam int DEF_CAPACITY = 64;
    localparam int CMD_W        = 3;
    localparam int VAL_W        = 32;
    localparam int IDX_W        = 16;

    localparam logic [CMD_W-1:0] CMD_APPEND  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_GET     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SHOW    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_REVERSE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CUT     = 3'd4;

    typedef enum logic [2:0] {
        ST_DATA  = 3'd0,
        ST_DONE  = 3'd1,
        ST_RANGE = 3'd2,
        ST_FULL  = 3'd3,
        ST_EMPTY = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_GET_OUT,
        S_SHOW_OUT,
        S_REV_RDI,
        S_REV_RDJ,
        S_REV_WRI,
        S_REV_WRJ,
        S_CUT_RD,
        S_CUT_WR,
        S_RES_DONE,
        S_RES_RANGE,
        S_RES_FULL,
        S_RES_EMPTY
    } t_state;

    typedef enum logic [2:0] {
        RA_FIRST,
        RA_PTR,
        RA_PTR_NEXT,
        RA_J,
        RA_SRC
    } t_rsel;

    typedef enum logic [1:0] {
        WA_LEN,
        WA_PTR,
        WA_J
    } t_wsel;

    typedef enum logic [1:0] {
        WD_VALUE,
        WD_RDATA,
        WD_HOLD
    } t_wdsel;

    typedef struct packed {
        logic    latch_in;
        logic    rd_en;
        t_rsel   rd_sel;
        logic    wr_en;
        t_wsel   wr_sel;
        t_wdsel  wd_sel;
        logic    len_inc;
        logic    len_cut;
        logic    ptr_clr;
        logic    ptr_inc;
        logic    j_init;
        logic    j_dec;
        logic    src_init;
        logic    src_inc;
        logic    hold_ld;
        logic    out_ld;
        logic    out_elem;
        t_status out_status;
        logic    out_last;
    } t_ile_cmd;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic             full;
        logic             empty;
        logic             short_list;
        logic             first_ok;
        logic             both_ok;
        logic             out_free;
        logic             ptr_last;
        logic             rev_end;
        logic             cut_end;
    } t_ile_stat;

endpackage

[hdl/ile_ctrl.sv]
// Controller state machine that sequences every command of the list engine.
`timescale 1ns / 1ps

module ile_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  ile_pkg::t_ile_stat i_stat,
    output ile_pkg::t_ile_cmd  o_cmd
);

    ile_pkg::t_state r_state;
    ile_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ile_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state) inside
            ile_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = ile_pkg::S_DECODE;
                end
            end
            ile_pkg::S_DECODE: begin
                unique case (i_stat.command)
                    ile_pkg::CMD_APPEND: begin
                        n_state = i_stat.full ? ile_pkg::S_RES_FULL : ile_pkg::S_RES_DONE;
                    end
                    ile_pkg::CMD_GET: begin
                        n_state = i_stat.first_ok ? ile_pkg::S_GET_OUT : ile_pkg::S_RES_RANGE;
                    end
                    ile_pkg::CMD_SHOW: begin
                        n_state = i_stat.empty ? ile_pkg::S_RES_EMPTY : ile_pkg::S_SHOW_OUT;
                    end
                    ile_pkg::CMD_REVERSE: begin
                        n_state = i_stat.short_list ? ile_pkg::S_RES_DONE : ile_pkg::S_REV_RDI;
                    end
                    ile_pkg::CMD_CUT: begin
                        n_state = i_stat.both_ok ? ile_pkg::S_CUT_RD : ile_pkg::S_RES_RANGE;
                    end
                    default: begin
                        n_state = ile_pkg::S_RES_DONE;
                    end
                endcase
            end
            ile_pkg::S_GET_OUT: begin
                if (i_stat.out_free) begin
                    n_state = ile_pkg::S_IDLE;
                end
            end
            ile_pkg::S_SHOW_OUT: begin
                if (i_stat.out_free && i_stat.ptr_last) begin
                    n_state = ile_pkg::S_IDLE;
                end
            end
            ile_pkg::S_REV_RDI: n_state = ile_pkg::S_REV_RDJ;
            ile_pkg::S_REV_RDJ: n_state = ile_pkg::S_REV_WRI;
            ile_pkg::S_REV_WRI: n_state = ile_pkg::S_REV_WRJ;
            ile_pkg::S_REV_WRJ: begin
                n_state = i_stat.rev_end ? ile_pkg::S_RES_DONE : ile_pkg::S_REV_RDI;
            end
            ile_pkg::S_CUT_RD: n_state = ile_pkg::S_CUT_WR;
            ile_pkg::S_CUT_WR: begin
                n_state = i_stat.cut_end ? ile_pkg::S_RES_DONE : ile_pkg::S_CUT_RD;
            end
            ile_pkg::S_RES_DONE, ile_pkg::S_RES_RANGE,
            ile_pkg::S_RES_FULL, ile_pkg::S_RES_EMPTY: begin
                if (i_stat.out_free) begin
                    n_state = ile_pkg::S_IDLE;
                end
            end
            default: n_state = ile_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd            = '0;
        o_cmd.rd_sel     = ile_pkg::RA_PTR;
        o_cmd.wr_sel     = ile_pkg::WA_PTR;
        o_cmd.wd_sel     = ile_pkg::WD_RDATA;
        o_cmd.out_status = ile_pkg::ST_DONE;
        o_in_ready       = 1'b0;
        unique case (r_state)
            ile_pkg::S_IDLE: begin
                o_in_ready     = 1'b1;
                o_cmd.latch_in = i_in_valid;
                o_cmd.ptr_clr  = i_in_valid;
            end
            ile_pkg::S_DECODE: begin
                unique case (i_stat.command)
                    ile_pkg::CMD_APPEND: begin
                        o_cmd.wr_en   = !i_stat.full;
                        o_cmd.wr_sel  = ile_pkg::WA_LEN;
                        o_cmd.wd_sel  = ile_pkg::WD_VALUE;
                        o_cmd.len_inc = !i_stat.full;
                    end
                    ile_pkg::CMD_GET: begin
                        o_cmd.rd_en  = i_stat.first_ok;
                        o_cmd.rd_sel = ile_pkg::RA_FIRST;
                    end
                    ile_pkg::CMD_SHOW: begin
                        o_cmd.rd_en = !i_stat.empty;
                    end
                    ile_pkg::CMD_REVERSE: begin
                        o_cmd.j_init = 1'b1;
                    end
                    ile_pkg::CMD_CUT: begin
                        o_cmd.src_init = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            ile_pkg::S_GET_OUT: begin
                o_cmd.out_ld     = i_stat.out_free;
                o_cmd.out_elem   = 1'b1;
                o_cmd.out_status = ile_pkg::ST_DATA;
                o_cmd.out_last   = 1'b1;
            end
            ile_pkg::S_SHOW_OUT: begin
                o_cmd.out_ld     = i_stat.out_free;
                o_cmd.out_elem   = 1'b1;
                o_cmd.out_status = ile_pkg::ST_DATA;
                o_cmd.out_last   = i_stat.ptr_last;
                o_cmd.ptr_inc    = i_stat.out_free && !i_stat.ptr_last;
                o_cmd.rd_en      = i_stat.out_free && !i_stat.ptr_last;
                o_cmd.rd_sel     = ile_pkg::RA_PTR_NEXT;
            end
            ile_pkg::S_REV_RDI: begin
                o_cmd.rd_en = 1'b1;
            end
            ile_pkg::S_REV_RDJ: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_sel  = ile_pkg::RA_J;
                o_cmd.hold_ld = 1'b1;
            end
            ile_pkg::S_REV_WRI: begin
                o_cmd.wr_en = 1'b1;
            end
            ile_pkg::S_REV_WRJ: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_sel  = ile_pkg::WA_J;
                o_cmd.wd_sel  = ile_pkg::WD_HOLD;
                o_cmd.ptr_inc = !i_stat.rev_end;
                o_cmd.j_dec   = !i_stat.rev_end;
            end
            ile_pkg::S_CUT_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = ile_pkg::RA_SRC;
            end
            ile_pkg::S_CUT_WR: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.len_cut = i_stat.cut_end;
                o_cmd.ptr_inc = !i_stat.cut_end;
                o_cmd.src_inc = !i_stat.cut_end;
            end
            ile_pkg::S_RES_DONE: begin
                o_cmd.out_ld   = i_stat.out_free;
                o_cmd.out_last = 1'b1;
            end
            ile_pkg::S_RES_RANGE: begin
                o_cmd.out_ld     = i_stat.out_free;
                o_cmd.out_status = ile_pkg::ST_RANGE;
                o_cmd.out_last   = 1'b1;
            end
            ile_pkg::S_RES_FULL: begin
                o_cmd.out_ld     = i_stat.out_free;
                o_cmd.out_status = ile_pkg::ST_FULL;
                o_cmd.out_last   = 1'b1;
            end
            ile_pkg::S_RES_EMPTY: begin
                o_cmd.out_ld     = i_stat.out_free;
                o_cmd.out_status = ile_pkg::ST_EMPTY;
                o_cmd.out_last   = 1'b1;
            end
            default: begin
            end
        endcase
    end

endmodule

[hdl/ile_datapath.sv]
// Datapath with the element memory, length, pointers and output register.
`timescale 1ns / 1ps

module ile_datapath #(
    parameter int CAPACITY = ile_pkg::DEF_CAPACITY
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ile_pkg::t_ile_cmd                 i_cmd,
    output ile_pkg::t_ile_stat                o_stat,
    input  logic [ile_pkg::CMD_W-1:0]         i_command,
    input  logic signed [ile_pkg::VAL_W-1:0]  i_value,
    input  logic signed [ile_pkg::IDX_W-1:0]  i_first_index,
    input  logic signed [ile_pkg::IDX_W-1:0]  i_second_index,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [ile_pkg::VAL_W-1:0]  o_element,
    output logic [2:0]                        o_status,
    output logic                              o_last
);

    localparam int AW  = $clog2(CAPACITY);
    localparam int LW  = $clog2(CAPACITY + 1);
    localparam int LW1 = LW + 1;
    localparam int VW  = ile_pkg::VAL_W;
    localparam int IW  = ile_pkg::IDX_W;

    logic [VW-1:0]            r_mem [CAPACITY];
    logic [VW-1:0]            r_rdata;
    logic [VW-1:0]            r_hold;
    logic [ile_pkg::CMD_W-1:0] r_command;
    logic [VW-1:0]            r_value;
    logic [IW-1:0]            r_first;
    logic [IW-1:0]            r_second;
    logic [LW-1:0]            r_len;
    logic [LW-1:0]            n_len;
    logic [AW-1:0]            r_ptr;
    logic [AW-1:0]            n_ptr;
    logic [AW-1:0]            r_j;
    logic [AW-1:0]            n_j;
    logic [AW-1:0]            r_src;
    logic [AW-1:0]            n_src;
    logic                     r_out_valid;
    logic                     n_out_valid;
    logic [VW-1:0]            r_out_element;
    logic [2:0]               r_out_status;
    logic                     r_out_last;

    logic [IW-1:0]  len_ext;
    logic [LW-1:0]  len_m1;
    logic [LW-1:0]  ptr_p1;
    logic [AW-1:0]  first_idx;
    logic [AW-1:0]  second_idx;
    logic [AW-1:0]  lo_idx;
    logic [AW-1:0]  hi_idx;
    logic [AW-1:0]  rd_addr;
    logic [AW-1:0]  wr_addr;
    logic [VW-1:0]  wr_data;
    logic           first_ok;
    logic           second_ok;
    logic           out_free;

    assign len_ext    = {{(IW-LW){1'b0}}, r_len};
    assign len_m1     = r_len - LW'(1);
    assign ptr_p1     = LW'(r_ptr) + LW'(1);
    assign first_idx  = r_first[AW-1:0];
    assign second_idx = r_second[AW-1:0];
    assign lo_idx     = (first_idx > second_idx) ? second_idx : first_idx;
    assign hi_idx     = (first_idx > second_idx) ? first_idx : second_idx;
    assign first_ok   = !r_first[IW-1] && (r_first < len_ext);
    assign second_ok  = !r_second[IW-1] && (r_second < len_ext);
    assign out_free   = !r_out_valid || i_out_ready;

    always_comb begin
        o_stat            = '0;
        o_stat.command    = r_command;
        o_stat.full       = (r_len == LW'(CAPACITY));
        o_stat.empty      = (r_len == '0);
        o_stat.short_list = (r_len < LW'(2));
        o_stat.first_ok   = first_ok;
        o_stat.both_ok    = first_ok && second_ok;
        o_stat.out_free   = out_free;
        o_stat.ptr_last   = (ptr_p1 == r_len);
        o_stat.rev_end    = ((LW1'(r_ptr) + LW1'(2)) >= LW1'(r_j));
        o_stat.cut_end    = (r_src == hi_idx);
    end

    always_comb begin
        case (i_cmd.rd_sel)
            ile_pkg::RA_FIRST:    rd_addr = first_idx;
            ile_pkg::RA_PTR_NEXT: rd_addr = r_ptr + AW'(1);
            ile_pkg::RA_J:        rd_addr = r_j;
            ile_pkg::RA_SRC:      rd_addr = r_src;
            default:              rd_addr = r_ptr;
        endcase
        case (i_cmd.wr_sel)
            ile_pkg::WA_LEN: wr_addr = r_len[AW-1:0];
            ile_pkg::WA_J:   wr_addr = r_j;
            default:         wr_addr = r_ptr;
        endcase
        case (i_cmd.wd_sel)
            ile_pkg::WD_VALUE: wr_data = r_value;
            ile_pkg::WD_HOLD:  wr_data = r_hold;
            default:           wr_data = r_rdata;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_comb begin
        n_len = r_len;
        if (i_cmd.len_inc) begin
            n_len = r_len + LW'(1);
        end else if (i_cmd.len_cut) begin
            n_len = ptr_p1;
        end
        n_ptr = r_ptr;
        if (i_cmd.ptr_clr) begin
            n_ptr = '0;
        end else if (i_cmd.ptr_inc) begin
            n_ptr = r_ptr + AW'(1);
        end
        n_j = r_j;
        if (i_cmd.j_init) begin
            n_j = len_m1[AW-1:0];
        end else if (i_cmd.j_dec) begin
            n_j = r_j - AW'(1);
        end
        n_src = r_src;
        if (i_cmd.src_init) begin
            n_src = lo_idx;
        end else if (i_cmd.src_inc) begin
            n_src = r_src + AW'(1);
        end
        n_out_valid = r_out_valid;
        if (i_cmd.out_ld) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_len       <= n_len;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr <= n_ptr;
        r_j   <= n_j;
        r_src <= n_src;
        if (i_cmd.latch_in) begin
            r_command <= i_command;
            r_value   <= i_value;
            r_first   <= i_first_index;
            r_second  <= i_second_index;
        end
        if (i_cmd.hold_ld) begin
            r_hold <= r_rdata;
        end
        if (i_cmd.out_ld) begin
            r_out_element <= i_cmd.out_elem ? r_rdata : '0;
            r_out_status  <= i_cmd.out_status;
            r_out_last    <= i_cmd.out_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_element   = r_out_element;
    assign o_status    = r_out_status;
    assign o_last      = r_out_last;

endmodule

[hdl/indexed_list_engine.sv]
// Top level of the indexed list engine: controller and datapath.
//
//   Channel   Direction  Handshake                     Payload
//   in        input      i_in_valid / o_in_ready       command, value, first/second index
//   out       output     o_out_valid / i_out_ready     element, status, last
//
// A command is accepted only in the idle state; the last result of the previous command
// may still wait in the output register. Show emits the elements one after another,
// reverse swaps each pair by reading both ends and writing them back, and cut copies each
// kept element by a read and then a write, set by the single read and single write port
// of the element memory. Reset clears the length and the output valid; a stalled output
// holds the controller in its result or output state.
`timescale 1ns / 1ps

module indexed_list_engine #(
    parameter int CAPACITY = ile_pkg::DEF_CAPACITY
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [ile_pkg::CMD_W-1:0]         i_command,
    input  logic signed [ile_pkg::VAL_W-1:0]  i_value,
    input  logic signed [ile_pkg::IDX_W-1:0]  i_first_index,
    input  logic signed [ile_pkg::IDX_W-1:0]  i_second_index,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [ile_pkg::VAL_W-1:0]  o_element,
    output logic [2:0]                        o_status,
    output logic                              o_last
);

    ile_pkg::t_ile_cmd  ctrl_cmd;
    ile_pkg::t_ile_stat dp_stat;

    ile_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (dp_stat),
        .o_cmd      (ctrl_cmd)
    );

    ile_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (ctrl_cmd),
        .o_stat         (dp_stat),
        .i_command      (i_command),
        .i_value        (i_value),
        .i_first_index  (i_first_index),
        .i_second_index (i_second_index),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_element      (o_element),
        .o_status       (o_status),
        .o_last         (o_last)
    );

endmodule

[hdl/ile_checker.sv]
// Port-level checker for the indexed list engine and its bind statement.
`timescale 1ns / 1ps
`include "indexed_list_engine_macros.svh"

module ile_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_ready,
    input logic [ile_pkg::CMD_W-1:0]         i_command,
    input logic signed [ile_pkg::VAL_W-1:0]  i_value,
    input logic signed [ile_pkg::IDX_W-1:0]  i_first_index,
    input logic signed [ile_pkg::IDX_W-1:0]  i_second_index,
    input logic                              o_out_valid,
    input logic                              i_out_ready,
    input logic signed [ile_pkg::VAL_W-1:0]  o_element,
    input logic [2:0]                        o_status,
    input logic                              o_last
);

    `ILE_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_element) && $stable(o_status) && $stable(o_last))
    `ILE_ASSERT(a_nondata_last, i_clk, i_rst_n, o_out_valid && (o_status != ile_pkg::ST_DATA) |-> o_last && (o_element == '0))
    `ILE_ASSERT(a_busy_mid_show, i_clk, i_rst_n, o_out_valid && !o_last |-> !o_in_ready)
    `ILE_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !o_out_valid)

endmodule

bind indexed_list_engine ile_checker u_ile_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .i_command      (i_command),
    .i_value        (i_value),
    .i_first_index  (i_first_index),
    .i_second_index (i_second_index),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_element      (o_element),
    .o_status       (o_status),
    .o_last         (o_last)
);

[verif/testbench.sv]
// Self-checking testbench for the indexed list engine, with a list predictor and scoreboard.
`timescale 1ns / 1ps

module testbench;
    import ile_pkg::*;

    localparam int CAPACITY      = DEF_CAPACITY;
    localparam int ITEM_TARGET   = 450;
    localparam int HOLD_CYCLES   = 200;
    localparam int SETTLE_CYCLES = 40;
    localparam int WATCHDOG_MAX  = 3000;

    typedef struct {
        logic signed [VAL_W-1:0] element;
        t_status                 status;
        logic                    last;
    } list_result_t;

    class list_scoreboard;
        logic signed [VAL_W-1:0] shadow_store [CAPACITY];
        int                      shadow_length;
        list_result_t            expected_results [$];
        int                      errors;

        function new();
            shadow_length = 0;
            errors        = 0;
        endfunction

        task report(string msg);
            $display("[%0t] %s", $time, msg);
            errors++;
        endtask

        function int pending();
            return expected_results.size();
        endfunction

        function bit index_valid(int idx);
            return idx >= 0 && idx < shadow_length;
        endfunction

        function void push_result(logic signed [VAL_W-1:0] element, t_status status,
                                  logic last);
            list_result_t r;
            r.element = element;
            r.status  = status;
            r.last    = last;
            expected_results.push_back(r);
        endfunction

        function void note_command(logic [CMD_W-1:0] cmd, logic signed [VAL_W-1:0] val,
                                   logic signed [IDX_W-1:0] a, logic signed [IDX_W-1:0] b);
            int                      lo;
            int                      hi;
            int                      first;
            int                      second;
            logic signed [VAL_W-1:0] tmp;
            first  = int'(a);
            second = int'(b);
            case (cmd)
                CMD_APPEND: begin
                    if (shadow_length >= CAPACITY) begin
                        push_result('0, ST_FULL, 1'b1);
                    end else begin
                        shadow_store[shadow_length] = val;
                        shadow_length++;
                        push_result('0, ST_DONE, 1'b1);
                    end
                end
                CMD_GET: begin
                    if (index_valid(first)) begin
                        push_result(shadow_store[first], ST_DATA, 1'b1);
                    end else begin
                        push_result('0, ST_RANGE, 1'b1);
                    end
                end
                CMD_SHOW: begin
                    if (shadow_length == 0) begin
                        push_result('0, ST_EMPTY, 1'b1);
                    end else begin
                        for (int i = 0; i < shadow_length; i++) begin
                            push_result(shadow_store[i], ST_DATA, i == shadow_length - 1);
                        end
                    end
                end
                CMD_REVERSE: begin
                    for (int i = 0; i < shadow_length / 2; i++) begin
                        tmp = shadow_store[i];
                        shadow_store[i] = shadow_store[shadow_length - 1 - i];
                        shadow_store[shadow_length - 1 - i] = tmp;
                    end
                    push_result('0, ST_DONE, 1'b1);
                end
                CMD_CUT: begin
                    if (!index_valid(first) || !index_valid(second)) begin
                        push_result('0, ST_RANGE, 1'b1);
                    end else begin
                        lo = (first < second) ? first : second;
                        hi = (first < second) ? second : first;
                        for (int i = 0; i <= hi - lo; i++) begin
                            shadow_store[i] = shadow_store[lo + i];
                        end
                        shadow_length = hi - lo + 1;
                        push_result('0, ST_DONE, 1'b1);
                    end
                end
                default: begin
                    push_result('0, ST_DONE, 1'b1);
                end
            endcase
        endfunction

        task check_result(logic signed [VAL_W-1:0] element, logic [2:0] status,
                          logic last);
            list_result_t e;
            if (expected_results.size() == 0) begin
                report($sformatf("unexpected result: element %0d status %0d last %0b",
                                 element, status, last));
                return;
            end
            e = expected_results.pop_front();
            if (element !== e.element) begin
                report($sformatf("element %0d, expected %0d", element, e.element));
            end
            if (status !== e.status) begin
                report($sformatf("status %0d, expected %0d", status, e.status));
            end
            if (last !== e.last) begin
                report($sformatf("last %0b, expected %0b", last, e.last));
            end
        endtask
    endclass

    logic                    i_clk          = 1'b0;
    logic                    i_rst_n        = 1'b0;
    logic                    i_in_valid     = 1'b0;
    logic                    o_in_ready;
    logic [CMD_W-1:0]        i_command      = '0;
    logic signed [VAL_W-1:0] i_value        = '0;
    logic signed [IDX_W-1:0] i_first_index  = '0;
    logic signed [IDX_W-1:0] i_second_index = '0;
    logic                    o_out_valid;
    logic                    i_out_ready    = 1'b0;
    logic signed [VAL_W-1:0] o_element;
    logic [2:0]              o_status;
    logic                    o_last;

    list_scoreboard sb = new();
    bit             offering    = 1'b0;
    bit             no_idle     = 1'b0;
    bit             hold_output = 1'b0;
    int             items_sent  = 0;
    int             quiet_cycles = 0;

    indexed_list_engine #(
        .CAPACITY(CAPACITY)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_command      (i_command),
        .i_value        (i_value),
        .i_first_index  (i_first_index),
        .i_second_index (i_second_index),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_element      (o_element),
        .o_status       (o_status),
        .o_last         (o_last)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_MAX) begin
            $display("watchdog expired after %0d quiet cycles", quiet_cycles);
            $display("indexed_list_engine: mismatch");
            $finish;
        end
    end

    task automatic send_command(input logic [CMD_W-1:0] cmd, input logic signed [VAL_W-1:0] val,
                                input logic signed [IDX_W-1:0] a,
                                input logic signed [IDX_W-1:0] b);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            if (offering) begin
                i_in_valid <= 1'b0;
                offering = 1'b0;
            end
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_command      <= cmd;
        i_value        <= val;
        i_first_index  <= a;
        i_second_index <= b;
        offering = 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_command(cmd, val, a, b);
        items_sent++;
    endtask

    task automatic idle_input();
        if (offering) begin
            i_in_valid <= 1'b0;
            offering = 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        idle_input();
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    function automatic logic signed [VAL_W-1:0] rand_value();
        case ($urandom_range(0, 7))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2:       return '0;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [IDX_W-1:0] rand_index();
        return IDX_W'($urandom);
    endfunction

    function automatic logic signed [IDX_W-1:0] pick_index(int n);
        int r;
        r = $urandom_range(0, 99);
        if (r < 85 && n > 0) begin
            return IDX_W'($urandom_range(0, n - 1));
        end
        case ($urandom_range(0, 4))
            0:       return -16'sd1;
            1:       return IDX_W'(n);
            2:       return 16'sh7FFF;
            3:       return 16'sh8000;
            default: return rand_index();
        endcase
    endfunction

    task automatic random_command();
        int                      pick;
        logic signed [IDX_W-1:0] a;
        logic signed [IDX_W-1:0] b;
        pick = $urandom_range(0, 99);
        if (sb.shadow_length < 4 && pick < 50) begin
            pick = 0;
        end
        a = pick_index(sb.shadow_length);
        b = pick_index(sb.shadow_length);
        if (pick < 35) begin
            send_command(CMD_APPEND, rand_value(), rand_index(), rand_index());
        end else if (pick < 55) begin
            send_command(CMD_GET, $urandom, a, rand_index());
        end else if (pick < 63) begin
            send_command(CMD_SHOW, $urandom, rand_index(), rand_index());
        end else if (pick < 71) begin
            send_command(CMD_REVERSE, $urandom, rand_index(), rand_index());
        end else if (pick < 86) begin
            send_command(CMD_CUT, $urandom, a, b);
        end else if (pick < 91) begin
            send_command(CMD_W'($urandom_range(5, 7)), $urandom, rand_index(), rand_index());
        end else begin
            send_command(CMD_W'($urandom_range(0, 7)), $urandom, rand_index(), rand_index());
        end
    endtask

    task automatic fill_list();
        while (sb.shadow_length < CAPACITY) begin
            send_command(CMD_APPEND, rand_value(), rand_index(), rand_index());
        end
        send_command(CMD_APPEND, rand_value(), rand_index(), rand_index());
        send_command(CMD_APPEND, rand_value(), rand_index(), rand_index());
        send_command(CMD_SHOW, $urandom, rand_index(), rand_index());
        send_command(CMD_REVERSE, $urandom, rand_index(), rand_index());
        send_command(CMD_GET, $urandom, IDX_W'(CAPACITY - 1), rand_index());
        send_command(CMD_GET, $urandom, IDX_W'(CAPACITY), rand_index());
        send_command(CMD_SHOW, $urandom, rand_index(), rand_index());
    endtask

    initial begin
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            int stall;
            if (hold_output) begin
                hold_output = 1'b0;
                stall = HOLD_CYCLES;
            end else begin
                stall = no_idle ? 0 : $urandom_range(0, 6);
            end
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            sb.check_result(o_element, o_status, o_last);
        end
    end

    initial begin
        int phase;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Operations on an empty list, then the unused command codes.
        send_command(CMD_SHOW, $urandom, rand_index(), rand_index());
        send_command(CMD_GET, $urandom, 16'sd0, 16'sd0);
        send_command(CMD_REVERSE, $urandom, rand_index(), rand_index());
        send_command(CMD_CUT, $urandom, 16'sd0, 16'sd0);
        send_command(3'd5, $urandom, rand_index(), rand_index());
        send_command(3'd6, $urandom, rand_index(), rand_index());
        send_command(3'd7, $urandom, rand_index(), rand_index());

        send_command(CMD_APPEND, 32'sh8000_0000, 16'sh7FFF, 16'sh8000);
        send_command(CMD_APPEND, 32'sh7FFF_FFFF, 16'sh8000, 16'sh7FFF);
        send_command(CMD_APPEND, 32'sd0, 16'sd0, 16'sd0);
        send_command(CMD_APPEND, -32'sd1, -16'sd1, -16'sd1);
        send_command(CMD_GET, $urandom, 16'sh8000, 16'sd0);
        send_command(CMD_GET, $urandom, 16'sh7FFF, 16'sd0);
        send_command(CMD_GET, $urandom, -16'sd1, 16'sd0);
        send_command(CMD_GET, $urandom, 16'sd4, 16'sd0);
        send_command(CMD_GET, $urandom, 16'sd0, 16'sd0);
        send_command(CMD_GET, $urandom, 16'sd3, 16'sd0);
        send_command(CMD_REVERSE, $urandom, rand_index(), rand_index());
        send_command(CMD_SHOW, $urandom, rand_index(), rand_index());
        send_command(CMD_CUT, $urandom, 16'sd3, 16'sd1);
        send_command(CMD_CUT, $urandom, -16'sd1, 16'sd0);
        send_command(CMD_CUT, $urandom, 16'sd0, 16'sh7FFF);
        send_command(CMD_CUT, $urandom, 16'sd1, 16'sd1);
        send_command(CMD_REVERSE, $urandom, rand_index(), rand_index());
        send_command(CMD_SHOW, $urandom, rand_index(), rand_index());
        drain_results();

        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            no_idle = (phase % 4 == 3);
            if (phase % 4 == 1) begin
                fill_list();
            end
            if (phase % 4 == 2) begin
                hold_output = 1'b1;
            end
            repeat (40) random_command();
            drain_results();
            phase++;
        end

        idle_input();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("indexed_list_engine: match");
        end else begin
            $display("indexed_list_engine: mismatch");
        end
        $finish;
    end
endmodule

[sim.f]
+incdir+hdl
hdl/ile_pkg.sv
hdl/ile_ctrl.sv
hdl/ile_datapath.sv
hdl/indexed_list_engine.sv
hdl/ile_checker.sv
verif/testbench.sv
